// File: rtl/kr_pkg.sv
// Shared constants and controller/datapath interface types for the keyed record table.
package kr_pkg;

    localparam int KEY_W = 16;
    localparam int VAL_W = 8;
    localparam int REC_W = KEY_W + VAL_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic       load;
        logic       append;
        logic       scan_step;
        logic       shift_init;
        logic       shift_step;
        logic       count_dec;
        logic       cap_value;
        logic       respond;
        logic [1:0] resp_status;
        logic       resp_found;
    } t_kr_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       hit;
        logic       last;
        logic       shift_done;
    } t_kr_sts;

endpackage

// File: rtl/keyed_record_table.sv
// Keyed record table top level: controller, datapath and result checks.
// A request is taken when start is high while busy is low; its result appears on
// o_status/o_found_value/o_count for one cycle with o_done and must be taken then.
// Insert and the unused op code go straight from decode to the response. Search and
// delete walk the record RAM one record per cycle; a search stops at the first match
// or after the last record, and a delete that hits moves every later record down by
// one slot before it responds. busy stays high for the whole request.
module keyed_record_table import kr_pkg::*; #(
    parameter int ENTRIES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_op,
    input  logic [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [7:0]       o_found_value,
    output logic [7:0]       o_count
);

    t_kr_cmd cmd;
    t_kr_sts sts;

    kr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    kr_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_count       (o_count)
    );

    // a result only ends a request in progress, and frees the block
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result without a request in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy && !o_done)
        else $error("request accepted but block not busy");

    a_value_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> o_found_value == 8'd0)
        else $error("found value reported on failed request");

endmodule

// File: rtl/kr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/kr_datapath.sv
// Datapath: request latches, record count, scan pointer, record RAM and result registers.
module kr_datapath import kr_pkg::*; #(
    parameter int ENTRIES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_op,
    input  logic [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0] i_value,
    input  t_kr_cmd          i_cmd,
    output t_kr_sts          o_sts,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [7:0]       o_found_value,
    output logic [7:0]       o_count
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [1:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_rd;
    logic             r_pv;
    logic [AW-1:0]    r_pidx;
    logic [VAL_W-1:0] r_fval;
    logic             r_done;
    logic [1:0]       r_status;
    logic [7:0]       r_found_value;
    logic [7:0]       r_count_o;

    logic             issue;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic [REC_W-1:0] ram_rdata;
    logic [CW+7:0]    count_ext;

    assign issue     = r_rd < r_count;
    assign ram_we    = i_cmd.append | (i_cmd.shift_step & r_pv);
    // shift moves the record just read down by one slot
    assign ram_waddr = i_cmd.append ? r_count[AW-1:0] : (r_pidx - AW'(1));
    assign ram_wdata = i_cmd.append ? {r_key, r_value} : ram_rdata;
    assign count_ext = {8'd0, r_count};

    kr_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.op         = r_op;
        o_sts.empty      = r_count == '0;
        o_sts.full       = r_count == CW'(ENTRIES);
        o_sts.hit        = r_pv && (ram_rdata[REC_W-1:VAL_W] == r_key);
        o_sts.last       = r_pv && ((CW'(r_pidx) + CW'(1)) == r_count);
        o_sts.shift_done = !r_pv && !issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rd <= '0;
                r_pv <= 1'b0;
            end else if (i_cmd.shift_init) begin
                r_rd <= CW'(r_pidx) + CW'(1);
                r_pv <= 1'b0;
            end else if (i_cmd.scan_step || i_cmd.shift_step) begin
                r_pv <= issue;
                if (issue) begin
                    r_rd <= r_rd + CW'(1);
                end
            end
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            r_done <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.scan_step || i_cmd.shift_step) begin
            r_pidx <= r_rd[AW-1:0];
        end
        if (i_cmd.cap_value) begin
            r_fval <= ram_rdata[VAL_W-1:0];
        end
        if (i_cmd.respond) begin
            r_status      <= i_cmd.resp_status;
            r_found_value <= i_cmd.resp_found ? r_fval : '0;
            r_count_o     <= count_ext[7:0];
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = r_found_value;
    assign o_count       = r_count_o;

endmodule

// File: rtl/kr_ctrl.sv
// Controller: sequences insert, linear search and delete-with-shift over the record RAM.
module kr_ctrl import kr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_kr_sts i_sts,
    output t_kr_cmd o_cmd,
    output logic    o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_st, n_st;
    logic       r_fnd, n_fnd;

    assign o_busy = r_state != S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_st    = r_st;
        n_fnd   = r_fnd;
        o_cmd.resp_status = r_st;
        o_cmd.resp_found  = r_fnd;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_st       = ST_OK;
                    n_fnd      = 1'b0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                unique case (i_sts.op)
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    OP_DELETE, OP_SEARCH: begin
                        if (i_sts.empty) begin
                            n_st = ST_NOT_FOUND;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    if (i_sts.op == OP_SEARCH) begin
                        o_cmd.cap_value = 1'b1;
                        n_fnd           = 1'b1;
                        n_state         = S_RESP;
                    end else begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end
                end else if (i_sts.last) begin
                    n_st    = ST_NOT_FOUND;
                    n_state = S_RESP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    o_cmd.count_dec = 1'b1;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_RESP: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
            r_fnd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_fnd   <= n_fnd;
        end
    end

endmodule

// File: tb/sv/keyed_record_table_tb.sv
// Self-checking testbench for keyed_record_table: directed rows, then random fill/drain/mix traffic.
module keyed_record_table_tb;
    import kr_pkg::*;

    localparam int ENTRIES = 128;
    localparam int N_ITEMS = 1650;
    localparam int QUIET_TAIL = 150;
    localparam int WATCHDOG_LIMIT = 8 * (ENTRIES + 16);
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] found;
        logic [7:0] count;
    } t_outcome;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             typed;
        t_outcome         want;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       i_op = OP_INSERT;
    logic [KEY_W-1:0] i_key = '0;
    logic [VAL_W-1:0] i_value = '0;
    logic             busy;
    logic             o_done;
    logic [1:0]       o_status;
    logic [7:0]       o_found_value;
    logic [7:0]       o_count;

    // predictor state
    logic [KEY_W-1:0] rec_keys [ENTRIES];
    logic [VAL_W-1:0] rec_vals [ENTRIES];
    int               rec_count = 0;

    t_outcome         outcome_q[$];
    logic [KEY_W-1:0] key_pool [16];
    int               errors = 0;
    int               items = 0;
    int               stall_cycles = 0;
    bit               idle_on = 1'b1;

    // rows whose result is obvious carry it; the rest go through the predictor
    t_dir_row dir_rows [19] = '{
        '{OP_SEARCH, 16'h0000, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'd0}},
        '{OP_DELETE, 16'hFFFF, 8'hFF, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'd0}},
        '{OP_NOP,    16'h0000, 8'h00, 1'b1, '{ST_OK,        8'h00, 8'd0}},
        '{OP_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{ST_OK,        8'h00, 8'd1}},
        '{OP_INSERT, 16'h0000, 8'h00, 1'b1, '{ST_OK,        8'h00, 8'd2}},
        '{OP_INSERT, 16'hFFFF, 8'h5A, 1'b1, '{ST_OK,        8'h00, 8'd3}},
        '{OP_SEARCH, 16'hFFFF, 8'h00, 1'b1, '{ST_OK,        8'hFF, 8'd3}},
        '{OP_SEARCH, 16'h0000, 8'hFF, 1'b1, '{ST_OK,        8'h00, 8'd3}},
        '{OP_SEARCH, 16'h1234, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'd3}},
        '{OP_DELETE, 16'hFFFF, 8'h00, 1'b1, '{ST_OK,        8'h00, 8'd2}},
        '{OP_SEARCH, 16'hFFFF, 8'h00, 1'b0, '{ST_OK,        8'h00, 8'd0}},
        '{OP_NOP,    16'hA5A5, 8'hC3, 1'b1, '{ST_OK,        8'h00, 8'd2}},
        '{OP_INSERT, 16'hAAAA, 8'hAA, 1'b0, '{ST_OK,        8'h00, 8'd0}},
        '{OP_INSERT, 16'h5555, 8'h55, 1'b0, '{ST_OK,        8'h00, 8'd0}},
        '{OP_DELETE, 16'h0000, 8'h00, 1'b0, '{ST_OK,        8'h00, 8'd0}},
        '{OP_SEARCH, 16'hAAAA, 8'h00, 1'b0, '{ST_OK,        8'h00, 8'd0}},
        '{OP_DELETE, 16'h5555, 8'h00, 1'b0, '{ST_OK,        8'h00, 8'd0}},
        '{OP_SEARCH, 16'h5555, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'd2}},
        '{OP_DELETE, 16'h1234, 8'h00, 1'b1, '{ST_NOT_FOUND, 8'h00, 8'd2}}
    };

    keyed_record_table #(.ENTRIES(ENTRIES)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_count       (o_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Applies one request to the predictor state and returns what the block should report.
    function automatic t_outcome table_outcome(logic [1:0] op, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] value);
        t_outcome res;
        int       hit;
        res = '{ST_OK, 8'h00, 8'h00};
        hit = -1;
        if (op == OP_DELETE || op == OP_SEARCH) begin
            for (int i = 0; i < rec_count; i++) begin
                if (hit < 0 && rec_keys[i] == key) hit = i;
            end
        end
        case (op)
            OP_INSERT: begin
                if (rec_count >= ENTRIES) begin
                    res.status = ST_FULL;
                end else begin
                    rec_keys[rec_count] = key;
                    rec_vals[rec_count] = value;
                    rec_count++;
                end
            end
            OP_DELETE: begin
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (int j = hit; j + 1 < rec_count; j++) begin
                        rec_keys[j] = rec_keys[j + 1];
                        rec_vals[j] = rec_vals[j + 1];
                    end
                    rec_count--;
                end
            end
            OP_SEARCH: begin
                if (hit < 0) res.status = ST_NOT_FOUND;
                else res.found = rec_vals[hit];
            end
            default: ;
        endcase
        res.count = rec_count[7:0];
        return res;
    endfunction

    // Presents one request, holds it until taken, then records the expected result.
    task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                                logic typed, t_outcome want);
        t_outcome pred;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        pred = table_outcome(op, key, value);
        outcome_q.push_back(typed ? want : pred);
        items++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return key_pool[$urandom_range(0, 15)];
        if (sel < 7 && rec_count > 0) return rec_keys[$urandom_range(0, rec_count - 1)];
        return KEY_W'($urandom);
    endfunction

    function automatic logic [1:0] pick_op();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 8) return OP_INSERT;
        if (sel < 13) return OP_DELETE;
        if (sel < 19) return OP_SEARCH;
        return OP_NOP;
    endfunction

    task automatic send_random(logic [1:0] op);
        send_request(op, pick_key(), VAL_W'($urandom), 1'b0, '0);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (i_rst_n && o_done) begin
            if (outcome_q.size() == 0) begin
                $error("result with no request pending: status %0d value %0d count %0d",
                       o_status, o_found_value, o_count);
                errors++;
            end else begin
                exp_res = outcome_q.pop_front();
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    errors++;
                end
                if (o_found_value !== exp_res.found) begin
                    $error("found_value: expected %0d, got %0d", exp_res.found, o_found_value);
                    errors++;
                end
                if (o_count !== exp_res.count) begin
                    $error("count: expected %0d, got %0d", exp_res.count, o_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 16; i++) key_pool[i] = KEY_W'($urandom);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_request(dir_rows[r].op, dir_rows[r].key, dir_rows[r].value,
                         dir_rows[r].typed, dir_rows[r].want);

        send_random(OP_NOP);
        for (int n = 0; n < 400; n++) send_random(pick_op());

        // fill to capacity, poke at the full table, then drain it
        for (int pass = 0; pass < 2; pass++) begin
            while (rec_count < ENTRIES) send_random(OP_INSERT);
            for (int n = 0; n < 12; n++) begin
                if (n % 3 == 0) send_random(OP_INSERT);
                else if (n % 3 == 1) send_request(OP_SEARCH, rec_keys[ENTRIES - 1],
                                                  VAL_W'($urandom), 1'b0, '0);
                else send_random(OP_SEARCH);
            end
            send_request(OP_DELETE, rec_keys[ENTRIES - 1], VAL_W'($urandom), 1'b0, '0);
            while (rec_count > 0) begin
                if ($urandom_range(0, 9) == 0) send_random(pick_op());
                else send_request(OP_DELETE, rec_keys[$urandom_range(0, rec_count - 1)],
                                  VAL_W'($urandom), 1'b0, '0);
            end
        end

        while (items < N_ITEMS) begin
            idle_on = (items < N_ITEMS - QUIET_TAIL);
            send_random(pick_op());
        end
        start <= 1'b0;

        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 10) @(posedge i_clk);

        if (errors == 0 && outcome_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/kr_pkg.sv
rtl/kr_ram.sv
rtl/kr_datapath.sv
rtl/kr_ctrl.sv
rtl/keyed_record_table.sv
tb/sv/keyed_record_table_tb.sv
